FILE: hw/rtl/drf_pkg.sv
// Shared types, widths and register codes for the detection row filter.
package drf_pkg;

  // Field widths of the element stream, the results and the registers.
  localparam int VALUE_W   = 24;
  localparam int CLASS_W   = 7;
  localparam int SCORE_W   = 13;
  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 15;
  localparam int SCALE_W   = 16;
  localparam int MASK_W    = 64;
  localparam int NC_W      = 8;
  localparam int POS_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  // Row layout and class limits.
  localparam int BOX_FIELDS      = 5;
  localparam int MAX_CLASSES_DEF = 128;

  // Entries in the queue between the row tracker and the box arithmetic.
  localparam int QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [NC_W-1:0]    NUM_CLASSES_RST = NC_W'(80);
  localparam logic [SCORE_W-1:0] THRESHOLD_RST   = SCORE_W'(2048);
  localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(4096);
  localparam logic [MASK_W-1:0]  MASK_RST        = '1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CLASSES     = 3'd0,
    REG_BOX_THRESHOLD   = 3'd1,
    REG_CLASS_THRESHOLD = 3'd2,
    REG_SCALE_X         = 3'd3,
    REG_SCALE_Y         = 3'd4,
    REG_CLASS_MASK_LOW  = 3'd5,
    REG_CLASS_MASK_HIGH = 3'd6
  } cfg_reg_t;

  // One finished row as handed from the row tracker to the arithmetic.
  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic [VALUE_W-1:0] best_score;
    logic [VALUE_W-1:0] objectness;
    logic [VALUE_W-1:0] center_x;
    logic [VALUE_W-1:0] center_y;
    logic [VALUE_W-1:0] width_raw;
    logic [VALUE_W-1:0] height_raw;
  } row_t;

  // Settings used by the filtering and scaling stages.
  typedef struct packed {
    logic [SCORE_W-1:0] box_threshold;
    logic [SCORE_W-1:0] class_threshold;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [MASK_W-1:0]  class_mask_low;
    logic [MASK_W-1:0]  class_mask_high;
  } back_cfg_t;

endpackage

FILE: hw/rtl/drf_front.sv
// Row tracker: takes elements, captures the box fields and runs the class argmax.
module drf_front import drf_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] element_value,
  input  logic               restart,
  input  logic [NC_W-1:0]    num_classes,
  input  logic               q_full,
  output logic               push,
  output row_t               push_row
);

  localparam logic [POS_W-1:0] POS_CX     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CY     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_W_RAW  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_H_RAW  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_OBJ    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SCORES = POS_W'(BOX_FIELDS);
  localparam logic [NC_W-1:0]  MAX_NC     = NC_W'(MAX_CLASSES);
  localparam logic [POS_W:0]   POS_LIMIT  = (POS_W+1)'(BOX_FIELDS + MAX_CLASSES - 1);

  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] center_x;
  logic [VALUE_W-1:0] center_y;
  logic [VALUE_W-1:0] width_raw;
  logic [VALUE_W-1:0] height_raw;
  logic [VALUE_W-1:0] objectness;
  logic [VALUE_W-1:0] best_score;
  logic [CLASS_W-1:0] best_class;

  logic               accept;
  logic [NC_W-1:0]    nc_eff;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   cls;
  logic               take_new;
  logic               last_score;
  logic [VALUE_W-1:0] best_score_next;
  logic [CLASS_W-1:0] best_class_next;

  // The queue has room for a finished row whenever an element is taken.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Class count clamped to the supported range.
  always_comb begin
    if (num_classes == '0) begin
      nc_eff = NC_W'(1);
    end else if (num_classes > MAX_NC) begin
      nc_eff = MAX_NC;
    end else begin
      nc_eff = num_classes;
    end
  end

  // Position of this element in its row and the running argmax.
  assign pos_cur         = restart ? POS_CX : position;
  assign cls             = pos_cur - POS_SCORES;
  assign take_new        = (cls == '0) || (element_value > best_score);
  assign best_score_next = take_new ? element_value : best_score;
  assign best_class_next = take_new ? cls[CLASS_W-1:0] : best_class;
  assign last_score      = ({1'b0, cls} + (POS_W+1)'(1)) >= {1'b0, nc_eff};

  // A row is handed on at its last class score.
  assign push = accept && (pos_cur >= POS_SCORES) && last_score;

  always_comb begin
    push_row.best_class = best_class_next;
    push_row.best_score = best_score_next;
    push_row.objectness = objectness;
    push_row.center_x   = center_x;
    push_row.center_y   = center_y;
    push_row.width_raw  = width_raw;
    push_row.height_raw = height_raw;
  end

  // Row position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      if ((pos_cur >= POS_SCORES) && last_score) begin
        position <= '0;
      end else begin
        position <= pos_cur + POS_W'(1);
      end
    end
  end

  // Box fields and argmax registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      width_raw  <= '0;
      height_raw <= '0;
      objectness <= '0;
      best_score <= '0;
      best_class <= '0;
    end else if (accept) begin
      case (pos_cur)
        POS_CX: begin
          center_x <= element_value;
        end
        POS_CY: begin
          center_y <= element_value;
        end
        POS_W_RAW: begin
          width_raw <= element_value;
        end
        POS_H_RAW: begin
          height_raw <= element_value;
        end
        POS_OBJ: begin
          objectness <= element_value;
        end
        default: begin
          best_score <= best_score_next;
          best_class <= best_class_next;
        end
      endcase
    end
  end

  // The position never runs past the last score of the largest row.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, position} <= POS_LIMIT)
    else $error("row position beyond last class score");

  // A finished row is only handed on when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("row handed on while queue full");

endmodule

FILE: hw/rtl/drf_queue.sv
// Short queue of finished rows between the row tracker and the box arithmetic.
module drf_queue import drf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  row_t push_row,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output row_t pop_row
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  row_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == DEPTH_C);
  assign pop_valid = (count != '0);
  assign pop_row   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_row;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // A pop only happens on a stored row.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue popped while empty");

  // The fill count rises by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");

endmodule

FILE: hw/rtl/drf_back.sv
// Row filter and box scaling pipeline with the result output register.
module drf_back import drf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  back_cfg_t           cfg,
  input  logic                q_valid,
  input  row_t                q_row,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CLASS_W-1:0]  class_id,
  output logic [SCORE_W-1:0]  confidence,
  output logic signed [COORD_W-1:0] box_left,
  output logic signed [COORD_W-1:0] box_top,
  output logic [SIZE_W-1:0]   box_width,
  output logic [SIZE_W-1:0]   box_height
);

  localparam int DIFF_W  = VALUE_W + 2;
  localparam int MAG_W   = VALUE_W + 1;
  localparam int EDGE_P  = MAG_W + SCALE_W;
  localparam int SIZE_P  = VALUE_W + SCALE_W;
  localparam int CONF_P  = 2 * VALUE_W;
  localparam int CONF_Q  = CONF_P - 12;
  localparam logic [SCORE_W-1:0] CONF_MAX = SCORE_W'(4096);

  // Edge in pixels: truncate the Q.25 magnitude, apply sign, saturate.
  function automatic logic [COORD_W-1:0] edge_sat(input logic neg,
                                                  input logic [EDGE_P-1:0] prod);
    logic [COORD_W-1:0] q;
    q = prod[EDGE_P-1:25];
    if (neg) begin
      edge_sat = (q > COORD_W'(32768)) ? COORD_W'(32768) : (~q + COORD_W'(1));
    end else begin
      edge_sat = (q > COORD_W'(32767)) ? COORD_W'(32767) : q;
    end
  endfunction

  // Size in pixels: truncate the Q.24 product, saturate.
  function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_P-1:0] prod);
    logic [SIZE_P-25:0] q;
    q = prod[SIZE_P-1:24];
    size_sat = (q > (SIZE_P-24)'(32767)) ? SIZE_W'(32767) : q[SIZE_W-1:0];
  endfunction

  logic en;

  // Filter stage registers.
  logic               s1_valid;
  logic               s1_keep;
  logic [CLASS_W-1:0] s1_class;
  logic [VALUE_W-1:0] s1_best;
  logic [VALUE_W-1:0] s1_obj;
  logic               s1_neg_x;
  logic               s1_neg_y;
  logic [MAG_W-1:0]   s1_mag_x;
  logic [MAG_W-1:0]   s1_mag_y;
  logic [VALUE_W-1:0] s1_w;
  logic [VALUE_W-1:0] s1_h;

  // Product stage registers.
  logic               s2_valid;
  logic [CLASS_W-1:0] s2_class;
  logic [CONF_P-1:0]  s2_conf;
  logic               s2_neg_x;
  logic               s2_neg_y;
  logic [EDGE_P-1:0]  s2_edge_x;
  logic [EDGE_P-1:0]  s2_edge_y;
  logic [SIZE_P-1:0]  s2_size_x;
  logic [SIZE_P-1:0]  s2_size_y;

  logic                     keep;
  logic [2*MASK_W-1:0]      mask_all;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0]        abs_x;
  logic [DIFF_W-1:0]        abs_y;
  logic [CONF_Q-1:0]        conf_q;

  // The whole pipeline moves unless a result waits at the output.
  assign en    = !out_valid || out_ready;
  assign q_pop = q_valid && en;

  // Threshold and class mask test on the popped row.
  assign mask_all = {cfg.class_mask_high, cfg.class_mask_low};
  assign keep = (q_row.objectness >= VALUE_W'(cfg.box_threshold))
             && (q_row.best_score >= VALUE_W'(cfg.class_threshold))
             && mask_all[q_row.best_class];

  // Left and top edges as 2*center - size in Q.13, split into sign and magnitude.
  assign diff_x = $signed({1'b0, q_row.center_x, 1'b0}) - $signed({2'b00, q_row.width_raw});
  assign diff_y = $signed({1'b0, q_row.center_y, 1'b0}) - $signed({2'b00, q_row.height_raw});
  assign abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_keep  <= keep;
      s1_class <= q_row.best_class;
      s1_best  <= q_row.best_score;
      s1_obj   <= q_row.objectness;
      s1_neg_x <= diff_x[DIFF_W-1];
      s1_neg_y <= diff_y[DIFF_W-1];
      s1_mag_x <= abs_x[MAG_W-1:0];
      s1_mag_y <= abs_y[MAG_W-1:0];
      s1_w     <= q_row.width_raw;
      s1_h     <= q_row.height_raw;
    end
  end

  // Multipliers; rows that failed the filter are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_class  <= s1_class;
      s2_conf   <= CONF_P'(s1_best) * CONF_P'(s1_obj);
      s2_neg_x  <= s1_neg_x;
      s2_neg_y  <= s1_neg_y;
      s2_edge_x <= EDGE_P'(s1_mag_x) * EDGE_P'(cfg.scale_x);
      s2_edge_y <= EDGE_P'(s1_mag_y) * EDGE_P'(cfg.scale_y);
      s2_size_x <= SIZE_P'(s1_w) * SIZE_P'(cfg.scale_x);
      s2_size_y <= SIZE_P'(s1_h) * SIZE_P'(cfg.scale_y);
    end
  end

  // Truncation and saturation into the output register.
  assign conf_q = s2_conf[CONF_P-1:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      class_id   <= s2_class;
      confidence <= (conf_q > CONF_Q'(CONF_MAX)) ? CONF_MAX : conf_q[SCORE_W-1:0];
      box_left   <= edge_sat(s2_neg_x, s2_edge_x);
      box_top    <= edge_sat(s2_neg_y, s2_edge_y);
      box_width  <= size_sat(s2_size_x);
      box_height <= size_sat(s2_size_y);
    end
  end

  // Confidence never exceeds one in Q1.12.
  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (confidence <= CONF_MAX))
    else $error("confidence above saturation limit");

  // A kept row in the product stage reaches the output on the next move.
  a_s2_to_out: assert property (@(posedge clk) disable iff (rst)
    (en && s2_valid) |=> out_valid)
    else $error("kept row lost between product stage and output");

endmodule

FILE: hw/rtl/detection_row_filter.sv
// Top level of the detection row filter: registers, row tracker, queue and arithmetic.
//
// The block takes one tensor element per cycle: a row is center x, center y, width,
// height, objectness and then num_classes class scores, and restart marks the first
// element of a row. in_ready is high whenever the four-entry row queue has room, so
// elements flow at one per cycle and the input only stalls once four finished rows wait
// in the queue behind a stalled output. At the last score of a row the row moves through
// the queue into a three-stage pipeline (threshold and mask test, multipliers, truncation
// and saturation); a kept detection goes from the queue through these stages in order to
// the output register, and rows that fail the test leave no result. Results leave one
// per cycle at most. Registers are written through cfg_write, cfg_index and cfg_data and
// are meant to change only while no row is in flight.
module detection_row_filter import drf_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VALUE_W-1:0]        element_value,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CLASS_W-1:0]        class_id,
  output logic [SCORE_W-1:0]        confidence,
  output logic signed [COORD_W-1:0] box_left,
  output logic signed [COORD_W-1:0] box_top,
  output logic [SIZE_W-1:0]         box_width,
  output logic [SIZE_W-1:0]         box_height
);

  logic [NC_W-1:0] num_classes;
  back_cfg_t       back_cfg;
  logic            q_full;
  logic            push;
  row_t            push_row;
  logic            q_pop;
  logic            q_valid;
  row_t            q_row;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes              <= NUM_CLASSES_RST;
      back_cfg.box_threshold   <= THRESHOLD_RST;
      back_cfg.class_threshold <= THRESHOLD_RST;
      back_cfg.scale_x         <= SCALE_RST;
      back_cfg.scale_y         <= SCALE_RST;
      back_cfg.class_mask_low  <= MASK_RST;
      back_cfg.class_mask_high <= MASK_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_CLASSES: begin
          num_classes <= cfg_data[NC_W-1:0];
        end
        REG_BOX_THRESHOLD: begin
          back_cfg.box_threshold <= cfg_data[SCORE_W-1:0];
        end
        REG_CLASS_THRESHOLD: begin
          back_cfg.class_threshold <= cfg_data[SCORE_W-1:0];
        end
        REG_SCALE_X: begin
          back_cfg.scale_x <= cfg_data[SCALE_W-1:0];
        end
        REG_SCALE_Y: begin
          back_cfg.scale_y <= cfg_data[SCALE_W-1:0];
        end
        REG_CLASS_MASK_LOW: begin
          back_cfg.class_mask_low <= cfg_data[MASK_W-1:0];
        end
        REG_CLASS_MASK_HIGH: begin
          back_cfg.class_mask_high <= cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Row tracker.
  drf_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .restart       (restart),
    .num_classes   (num_classes),
    .q_full        (q_full),
    .push          (push),
    .push_row      (push_row)
  );

  // Finished rows waiting for the arithmetic.
  drf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_row  (push_row),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_row   (q_row)
  );

  // Filter, scaling and output register.
  drf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (back_cfg),
    .q_valid    (q_valid),
    .q_row      (q_row),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .class_id   (class_id),
    .confidence (confidence),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height)
  );

endmodule

FILE: sim/detection_row_filter_tb.sv
// Self-checking testbench for the detection row filter: directed rows, then random phases.
`timescale 1ns / 100ps

module detection_row_filter_tb;
  import drf_pkg::*;

  localparam logic [VALUE_W-1:0] FULL = '1;
  localparam int TOTAL_ITEMS   = 600;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PERCENT  = 29;

  // One detection as it leaves the block.
  typedef struct packed {
    logic [CLASS_W-1:0]        cls;
    logic [SCORE_W-1:0]        conf;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         wid;
    logic [SIZE_W-1:0]         hgt;
  } detection_t;

  // Full register set of the block.
  typedef struct {
    logic [NC_W-1:0]    nc;
    logic [SCORE_W-1:0] bthr;
    logic [SCORE_W-1:0] cthr;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [MASK_W-1:0]  mlo;
    logic [MASK_W-1:0]  mhi;
  } settings_t;

  // One element of the directed sequence; fixed marks a hand-computed detection.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               first;
    bit                 fixed;
    detection_t         det;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [VALUE_W-1:0]        element_value;
  logic                      restart;
  logic                      out_valid;
  logic                      out_ready;
  logic [CLASS_W-1:0]        class_id;
  logic [SCORE_W-1:0]        confidence;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic [SIZE_W-1:0]         box_width;
  logic [SIZE_W-1:0]         box_height;

  // Predictor copy of the registers and of the row tracker.
  settings_t          active;
  logic [POS_W-1:0]   row_pos;
  logic [VALUE_W-1:0] cx, cy, wraw, hraw, obj, best_score;
  logic [CLASS_W-1:0] best_class;

  detection_t pending_detections[$];
  stim_row_t  directed_steps[$];
  int         mismatches = 0;
  int         elements_sent = 0;
  bit         calm = 1'b0;

  detection_row_filter uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .element_value(element_value), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .class_id(class_id), .confidence(confidence),
    .box_left(box_left), .box_top(box_top),
    .box_width(box_width), .box_height(box_height)
  );

  always #4 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("detection_row_filter_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Out-of-range class counts are clamped to 1..MAX_CLASSES.
  function automatic int class_count(input logic [NC_W-1:0] nc);
    if (nc == 0) return 1;
    if (nc > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
    return int'(nc);
  endfunction

  // Edge in pixels: (2c - size) in Q.13 times a Q.12 scale, truncated toward zero.
  function automatic logic [COORD_W-1:0] edge_px(input logic [VALUE_W-1:0] c,
                                                 input logic [VALUE_W-1:0] size,
                                                 input logic [SCALE_W-1:0] scale);
    longint d;
    longint unsigned mag;
    longint unsigned q;
    d = 2 * longint'(c) - longint'(size);
    mag = (d < 0) ? longint'(-d) : longint'(d);
    mag = mag * longint'(scale);
    q = mag >> 25;
    if (d < 0) return (q > 32768) ? 16'h8000 : COORD_W'(-longint'(q));
    return (q > 32767) ? 16'h7FFF : COORD_W'(q);
  endfunction

  function automatic logic [SIZE_W-1:0] size_px(input logic [VALUE_W-1:0] size,
                                                input logic [SCALE_W-1:0] scale);
    longint unsigned q;
    q = (longint'(size) * longint'(scale)) >> 24;
    return (q > 32767) ? 15'h7FFF : SIZE_W'(q);
  endfunction

  // Advances the row tracker by one element; returns 1 when a detection is kept.
  function automatic bit predict_element(input logic [VALUE_W-1:0] v, input logic first,
                                         output detection_t d);
    int nc;
    int cls;
    bit keep;
    longint unsigned prod;
    d = '0;
    nc = class_count(active.nc);
    if (first) row_pos = '0;
    if (row_pos < BOX_FIELDS) begin
      case (row_pos)
        0: cx = v;
        1: cy = v;
        2: wraw = v;
        3: hraw = v;
        default: obj = v;
      endcase
      row_pos = row_pos + 1'b1;
      return 1'b0;
    end
    // Running argmax keeps the first index of the highest score.
    cls = int'(row_pos) - BOX_FIELDS;
    if (cls == 0 || v > best_score) begin
      best_score = v;
      best_class = CLASS_W'(cls);
    end
    if (cls + 1 < nc) begin
      row_pos = row_pos + 1'b1;
      return 1'b0;
    end
    row_pos = '0;
    keep = (obj >= active.bthr) && (best_score >= active.cthr);
    if (best_class < 64) keep = keep && active.mlo[best_class[5:0]];
    else keep = keep && active.mhi[best_class[5:0]];
    if (!keep) return 1'b0;
    prod = (longint'(best_score) * longint'(obj)) >> 12;
    d.cls  = best_class;
    d.conf = (prod > 4096) ? SCORE_W'(4096) : SCORE_W'(prod);
    d.left = edge_px(cx, wraw, active.sx);
    d.top  = edge_px(cy, hraw, active.sy);
    d.wid  = size_px(wraw, active.sx);
    d.hgt  = size_px(hraw, active.sy);
    return 1'b1;
  endfunction

  function automatic detection_t det_of(input int c, input int f, input int l, input int t,
                                        input int w, input int h);
    detection_t d;
    d.cls  = CLASS_W'(c);
    d.conf = SCORE_W'(f);
    d.left = COORD_W'(l);
    d.top  = COORD_W'(t);
    d.wid  = SIZE_W'(w);
    d.hgt  = SIZE_W'(h);
    return d;
  endfunction

  function automatic stim_row_t step_of(input logic [VALUE_W-1:0] v, input logic first,
                                        input bit fixed, input detection_t d);
    stim_row_t s;
    s.value = v;
    s.first = first;
    s.fixed = fixed;
    s.det   = d;
    return s;
  endfunction

  // Appends one element to the directed sequence.
  task automatic add_step(input logic [VALUE_W-1:0] v, input logic first,
                          input bit fixed, input detection_t d);
    directed_steps = {directed_steps, step_of(v, first, fixed, d)};
  endtask

  // Element values lean toward the Q1.12 range where thresholds live.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FULL;
      2, 3: return VALUE_W'($urandom);
      default: return VALUE_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SCORE_W'(4096);
      default: return SCORE_W'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return SCALE_RST;
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  // The first phases pin the extremes; later ones are random, mostly with few classes.
  function automatic settings_t pick_settings(input int phase);
    settings_t s;
    s.nc   = ($urandom_range(0, 7) == 0) ? NC_W'($urandom_range(7, 40))
                                         : NC_W'($urandom_range(1, 6));
    s.bthr = pick_threshold();
    s.cthr = pick_threshold();
    s.sx   = pick_scale();
    s.sy   = pick_scale();
    s.mlo  = $urandom_range(0, 1) ? MASK_RST : {$urandom, $urandom};
    s.mhi  = $urandom_range(0, 1) ? MASK_RST : {$urandom, $urandom};
    case (phase)
      0: begin
        s.nc = '0;
        s.bthr = '0;
        s.cthr = '0;
        s.sx = '1;
        s.sy = '1;
        s.mlo = MASK_RST;
        s.mhi = MASK_RST;
      end
      1: begin
        s.nc = '1;
        s.bthr = '0;
        s.cthr = '0;
        s.sx = '0;
        s.sy = '0;
      end
      2: begin
        s.bthr = '1;
        s.cthr = '1;
        s.mlo = '0;
        s.mhi = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic write_settings(input settings_t s);
    put_reg(REG_NUM_CLASSES, CFG_W'(s.nc));
    put_reg(REG_BOX_THRESHOLD, CFG_W'(s.bthr));
    put_reg(REG_CLASS_THRESHOLD, CFG_W'(s.cthr));
    put_reg(REG_SCALE_X, CFG_W'(s.sx));
    put_reg(REG_SCALE_Y, CFG_W'(s.sy));
    put_reg(REG_CLASS_MASK_LOW, s.mlo);
    put_reg(REG_CLASS_MASK_HIGH, s.mhi);
    @(negedge clk);
    cfg_write <= 1'b0;
    active = s;
  endtask

  // Drives one element and predicts its result once the transfer has happened.
  task automatic send_element(input logic [VALUE_W-1:0] v, input logic first,
                              input bit fixed, input detection_t fixed_det);
    detection_t d;
    bit got;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    restart       <= first;
    do @(posedge clk); while (!in_ready);
    got = predict_element(v, first, d);
    if (fixed) pending_detections = {pending_detections, fixed_det};
    else if (got) pending_detections = {pending_detections, d};
    elements_sent++;
  endtask

  // A row with random content; now and then it is cut short or carries a stray restart.
  task automatic send_row();
    int len;
    int cut;
    logic first;
    len = BOX_FIELDS + class_count(active.nc);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < cut; i++) begin
      if (i == 0) first = ($urandom_range(0, 3) != 0);
      else first = ($urandom_range(0, 199) == 0);
      send_element(pick_value(), first, 1'b0, '0);
    end
  endtask

  // Waits until every due detection is out and the pipeline has settled.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side stalls at random, except in the calm phase.
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each result transfer with the oldest due detection.
  always @(posedge clk) begin : check_results
    detection_t due;
    if (!rst && out_valid && out_ready) begin
      if (pending_detections.size() == 0) begin
        report_mismatch("result transfer with no detection due");
      end else begin
        due = pending_detections.pop_front();
        if (class_id !== due.cls)
          report_mismatch($sformatf("class_id %0d, want %0d", class_id, due.cls));
        if (confidence !== due.conf)
          report_mismatch($sformatf("confidence %0d, want %0d", confidence, due.conf));
        if (box_left !== due.left)
          report_mismatch($sformatf("box_left %0d, want %0d", box_left, due.left));
        if (box_top !== due.top)
          report_mismatch($sformatf("box_top %0d, want %0d", box_top, due.top));
        if (box_width !== due.wid)
          report_mismatch($sformatf("box_width %0d, want %0d", box_width, due.wid));
        if (box_height !== due.hgt)
          report_mismatch($sformatf("box_height %0d, want %0d", box_height, due.hgt));
      end
    end
  end

  initial begin
    settings_t s;
    int phase;
    int sent_before;
    int budget;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_NUM_CLASSES;
    cfg_data      = '0;
    in_valid      = 1'b0;
    element_value = '0;
    restart       = 1'b0;
    out_ready     = 1'b0;

    // Predictor starts from the reset values.
    active.nc   = NUM_CLASSES_RST;
    active.bthr = THRESHOLD_RST;
    active.cthr = THRESHOLD_RST;
    active.sx   = SCALE_RST;
    active.sy   = SCALE_RST;
    active.mlo  = MASK_RST;
    active.mhi  = MASK_RST;
    row_pos = '0;
    {cx, cy, wraw, hraw, obj, best_score} = '0;
    best_class = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows with two classes at unit scale.
    // A nominal box: center (100, 50), size 20 x 10, class 1 wins.
    add_step(24'd409600, 1'b1, 1'b0, '0);
    add_step(24'd204800, 1'b0, 1'b0, '0);
    add_step(24'd81920, 1'b0, 1'b0, '0);
    add_step(24'd40960, 1'b0, 1'b0, '0);
    add_step(24'd4096, 1'b0, 1'b0, '0);
    add_step(24'd2048, 1'b0, 1'b0, '0);
    add_step(24'd4096, 1'b0, 1'b1, det_of(1, 4096, 90, 45, 20, 10));
    // All ones, starting without restart: a tie picks class 0, confidence saturates.
    for (int i = 0; i < 6; i++) add_step(FULL, 1'b0, 1'b0, '0);
    add_step(FULL, 1'b0, 1'b1, det_of(0, 4096, 2047, 2047, 4095, 4095));
    // A row abandoned by a restart after one element.
    add_step(24'h5A5A5A, 1'b1, 1'b0, '0);
    // Negative edges, with objectness and score exactly at their thresholds.
    add_step('0, 1'b1, 1'b0, '0);
    add_step('0, 1'b0, 1'b0, '0);
    add_step(FULL, 1'b0, 1'b0, '0);
    add_step(FULL, 1'b0, 1'b0, '0);
    add_step(24'd2048, 1'b0, 1'b0, '0);
    add_step('0, 1'b0, 1'b0, '0);
    add_step(24'd2048, 1'b0, 1'b1, det_of(1, 1024, -2047, -2047, 4095, 4095));

    s = active;
    s.nc = NC_W'(2);
    write_settings(s);
    foreach (directed_steps[i]) begin
      send_element(directed_steps[i].value, directed_steps[i].first,
                   directed_steps[i].fixed, directed_steps[i].det);
    end
    drain();

    // Class count lowered mid-row: the next score closes the row.
    s.nc = NC_W'(3);
    write_settings(s);
    send_element(24'd409600, 1'b1, 1'b0, '0);
    for (int i = 0; i < 5; i++) send_element(pick_value(), 1'b0, 1'b0, '0);
    drain();
    s.nc = NC_W'(1);
    s.bthr = '0;
    s.cthr = '0;
    write_settings(s);
    send_element(pick_value(), 1'b0, 1'b0, '0);
    drain();

    // Random phases, each under its own settings.
    for (phase = 0; phase < 200 && elements_sent < TOTAL_ITEMS; phase++) begin
      s = pick_settings(phase);
      calm = (phase == 3);
      budget = calm ? 150 : 60;
      write_settings(s);
      sent_before = elements_sent;
      do send_row(); while (elements_sent - sent_before < budget);
      drain();
    end

    if (mismatches == 0) begin
      $display("detection_row_filter_tb: clean");
    end else begin
      $display("detection_row_filter_tb: errors");
    end
    $finish;
  end

endmodule
